FILE: src/trmh_pkg.sv
// Shared types and constants for the threshold run merger histogram block.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package trmh_pkg;

    localparam int HIST_CLIP   = 1024;
    localparam int HIST_DEPTH  = HIST_CLIP + 1;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int MAX_BINS    = 1048576;
    localparam int POS_W       = 21;
    localparam int START_W     = 20;
    localparam int COUNT_W     = 16;
    localparam int IDX_W       = 11;
    localparam int SUM_W       = 36;
    localparam int HVAL_W      = 32;
    localparam int TOTAL_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic REQ_BIN   = 1'b0;
    localparam logic REQ_HIST  = 1'b1;
    localparam logic KIND_RUN  = 1'b0;
    localparam logic KIND_HIST = 1'b1;

    // Input word layout
    localparam int S_TDATA_W   = 32;
    localparam int S_COUNT_LO  = 0;
    localparam int S_FIRST_BIT = S_COUNT_LO + COUNT_W;
    localparam int S_IDX_LO    = S_FIRST_BIT + 1;

    // Result word layout
    localparam int M_START_LO  = 0;
    localparam int M_END_LO    = M_START_LO + START_W;
    localparam int M_READS_LO  = M_END_LO + POS_W;
    localparam int M_HVAL_LO   = M_READS_LO + SUM_W;
    localparam int M_TOTAL_LO  = M_HVAL_LO + HVAL_W;
    localparam int M_USED_W    = M_TOTAL_LO + TOTAL_W;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

    typedef struct packed {
        logic                 is_read;
        logic                 in_range;
        logic                 marked;
        logic                 first;
        logic                 last;
        logic [COUNT_W-1:0]   count;
        logic [HIST_AW-1:0]   addr;
    } trmh_item_t;

endpackage

`default_nettype wire

FILE: src/trmh_front.sv
// Input side: threshold register, word classification and histogram address selection.
// Depends on trmh_pkg; feeds trmh_queue.
`default_nettype none

module trmh_front import trmh_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // bin_count, first_bin, hist_index, zero pad
    input  wire logic                 s_tuser,   // req_type
    input  wire logic                 s_tlast,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [COUNT_W-1:0]   cfg_data,
    input  wire logic                 clear_busy,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output trmh_item_t                push_item
);

    logic [COUNT_W-1:0] threshold_reg;
    logic [COUNT_W-1:0] count;
    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic [HIST_AW-1:0] clip_addr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            threshold_reg <= cfg_data;
        end
    end

    always_comb begin
        count     = s_tdata[S_COUNT_LO +: COUNT_W];
        idx       = s_tdata[S_IDX_LO +: IDX_W];
        in_range  = (idx <= IDX_W'(HIST_CLIP));
        clip_addr = (count > COUNT_W'(HIST_CLIP)) ? HIST_AW'(HIST_CLIP) : HIST_AW'(count);

        push_item.is_read  = (s_tuser == REQ_HIST);
        push_item.in_range = in_range;
        push_item.marked   = (count > threshold_reg);
        push_item.first    = s_tdata[S_FIRST_BIT];
        push_item.last     = s_tlast;
        push_item.count    = count;
        if (s_tuser == REQ_HIST) begin
            push_item.addr = in_range ? HIST_AW'(idx) : '0;
        end else begin
            push_item.addr = clip_addr;
        end
    end

    assign push_valid = s_tvalid && !clear_busy;
    assign s_tready   = push_ready && !clear_busy;

endmodule

`default_nettype wire

FILE: src/trmh_queue.sv
// Short word queue between the front and back parts.
// Depends on trmh_pkg for the item type and depth.
`default_nettype none

module trmh_queue import trmh_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push_valid,
    output logic             push_ready,
    input  wire trmh_item_t  push_item,
    output logic             pop_valid,
    input  wire logic        pop_ready,
    output trmh_item_t       pop_item
);

    trmh_item_t          slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   fill_reg;
    logic [QUEUE_AW:0]   fill_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (fill_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        fill_next = fill_reg;
        unique case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: src/trmh_back.sv
// Back part: histogram memory with clearing sweep and write forwarding, run tracking,
// marked-bin total and the result register. Depends on trmh_pkg.
`default_nettype none

module trmh_back import trmh_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 pop_valid,
    output logic                      pop_ready,
    input  wire trmh_item_t           pop_item,
    output logic                      clear_busy,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // start, end, reads, hist value, marked, pad
    output logic                      m_tuser    // result_kind
);

    logic [HVAL_W-1:0]  hist_mem [HIST_DEPTH];

    logic               clear_busy_reg;
    logic [HIST_AW-1:0] clr_addr_reg;

    logic               b_valid_reg;
    trmh_item_t         b_item_reg;
    logic [HVAL_W-1:0]  rd_data_reg;
    logic               fwd_hit_reg;
    logic [HVAL_W-1:0]  fwd_data_reg;

    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic               open_reg,  open_next;
    logic [START_W-1:0] first_reg, first_next;
    logic [SUM_W-1:0]   sum_reg,   sum_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic               m_valid_reg;
    logic               out_kind_reg;
    logic [START_W-1:0] out_start_reg;
    logic [POS_W-1:0]   out_end_reg;
    logic [SUM_W-1:0]   out_reads_reg;
    logic [HVAL_W-1:0]  out_hval_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    logic               b_fire;
    logic               b_write;
    logic               pop_fire;
    logic [HVAL_W-1:0]  cur_val;
    logic [HVAL_W-1:0]  inc_val;

    logic [POS_W-1:0]   pos_e;
    logic [POS_W-1:0]   pos_inc;
    logic               open_e;
    logic [START_W-1:0] first_e;
    logic [SUM_W-1:0]   sum_e;
    logic [SUM_W:0]     sum_add;
    logic               run_emit;
    logic [START_W-1:0] emit_start;
    logic [POS_W-1:0]   emit_end;
    logic [SUM_W-1:0]   emit_reads;

    assign clear_busy = clear_busy_reg;
    assign b_fire     = b_valid_reg && (!m_valid_reg || m_tready);
    assign b_write    = b_fire && !b_item_reg.is_read;
    assign pop_ready  = !b_valid_reg || b_fire;
    assign pop_fire   = pop_valid && pop_ready;

    assign cur_val = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign inc_val = (cur_val == '1) ? cur_val : cur_val + 1'b1;

    // Clearing sweep after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clear_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == HIST_AW'(HIST_CLIP)) begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clear_busy_reg) begin
            hist_mem[clr_addr_reg] <= '0;
        end else if (b_write) begin
            hist_mem[b_item_reg.addr] <= inc_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_fire) begin
            rd_data_reg  <= hist_mem[pop_item.addr];
            fwd_hit_reg  <= b_write && (b_item_reg.addr == pop_item.addr);
            fwd_data_reg <= inc_val;
            b_item_reg   <= pop_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (pop_ready) begin
            b_valid_reg <= pop_valid;
        end
    end

    // Run tracking
    always_comb begin
        pos_e   = b_item_reg.first ? '0 : pos_reg;
        open_e  = b_item_reg.first ? 1'b0 : open_reg;
        first_e = b_item_reg.first ? '0 : first_reg;
        sum_e   = b_item_reg.first ? '0 : sum_reg;
        pos_inc = pos_e + 1'b1;
        sum_add = {1'b0, sum_e} + (SUM_W+1)'(b_item_reg.count);

        total_next = total_reg;
        if (b_item_reg.marked && (total_reg != '1)) begin
            total_next = total_reg + 1'b1;
        end

        pos_next   = pos_e;
        open_next  = open_e;
        first_next = first_e;
        sum_next   = sum_e;
        run_emit   = 1'b0;
        emit_start = first_e;
        emit_end   = pos_e;
        emit_reads = sum_e;

        priority if (pos_e >= POS_W'(MAX_BINS)) begin
            pos_next = POS_W'(MAX_BINS);
            if (open_e) begin
                run_emit   = 1'b1;
                open_next  = 1'b0;
                first_next = '0;
                sum_next   = '0;
            end
        end else if (b_item_reg.marked) begin
            if (!open_e) begin
                emit_start = pos_e[START_W-1:0];
                emit_reads = SUM_W'(b_item_reg.count);
            end else begin
                emit_reads = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            end
            emit_end = pos_inc;
            pos_next = pos_inc;
            if (b_item_reg.last) begin
                run_emit   = 1'b1;
                open_next  = 1'b0;
                first_next = '0;
                sum_next   = '0;
            end else begin
                open_next  = 1'b1;
                first_next = emit_start;
                sum_next   = emit_reads;
            end
        end else begin
            if (open_e) begin
                run_emit   = 1'b1;
                open_next  = 1'b0;
                first_next = '0;
                sum_next   = '0;
            end
            pos_next = pos_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            open_reg  <= 1'b0;
            first_reg <= '0;
            sum_reg   <= '0;
            total_reg <= '0;
        end else if (b_write) begin
            pos_reg   <= pos_next;
            open_reg  <= open_next;
            first_reg <= first_next;
            sum_reg   <= sum_next;
            total_reg <= total_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_fire) begin
            m_valid_reg <= b_item_reg.is_read || run_emit;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire) begin
            if (b_item_reg.is_read) begin
                out_kind_reg  <= KIND_HIST;
                out_start_reg <= '0;
                out_end_reg   <= '0;
                out_reads_reg <= '0;
                out_hval_reg  <= b_item_reg.in_range ? cur_val : '0;
                out_total_reg <= total_reg;
            end else begin
                out_kind_reg  <= KIND_RUN;
                out_start_reg <= emit_start;
                out_end_reg   <= emit_end;
                out_reads_reg <= emit_reads;
                out_hval_reg  <= '0;
                out_total_reg <= total_next;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {(M_TDATA_W - M_USED_W)'(0), out_total_reg, out_hval_reg,
                       out_reads_reg, out_end_reg, out_start_reg};

endmodule

`default_nettype wire

FILE: src/threshold_run_merger_histogram.sv
// Top level of the threshold run merger histogram block.
// Instantiates trmh_front, trmh_queue and trmh_back; depends on trmh_pkg.
//
//  channel   handshake              payload
//  s_        s_tvalid / s_tready    s_tdata, s_tuser (req_type), s_tlast (last_bin)
//  m_        m_tvalid / m_tready    m_tdata, m_tuser (result_kind)
//  cfg_      cfg_valid / cfg_ready  cfg_data (threshold)
//
// One input word per cycle sustained while neither the clearing pass nor a stalled m_ side
// holds s_tready low; a result passes the queue stage, the histogram read register and the
// result register. After reset a clearing pass zeroes the 1025-entry histogram; s_tready
// stays low meanwhile, cfg writes are taken throughout. A stalled m_ side fills the four-entry
// queue before s_tready drops.
`default_nettype none

module threshold_run_merger_histogram import trmh_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // bin_count, first_bin, hist_index, zero pad
    input  wire logic                 s_tuser,   // req_type
    input  wire logic                 s_tlast,   // last_bin
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // start, end, reads, hist value, marked, pad
    output logic                      m_tuser,   // result_kind
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [COUNT_W-1:0]   cfg_data
);

    logic       clear_busy;
    logic       push_valid;
    logic       push_ready;
    trmh_item_t push_item;
    logic       pop_valid;
    logic       pop_ready;
    trmh_item_t pop_item;

    trmh_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .clear_busy (clear_busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    trmh_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    trmh_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    a_no_result_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !m_tvalid)
        else $error("result presented during histogram clearing");

    a_run_end_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_RUN)) |->
        (m_tdata[M_END_LO +: POS_W] > POS_W'(m_tdata[M_START_LO +: START_W])))
        else $error("run record end does not follow its start");

    a_hist_run_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_HIST)) |-> (m_tdata[M_HVAL_LO-1:0] == '0))
        else $error("histogram result carries run fields");

endmodule

`default_nettype wire

FILE: bench/trmh_checker.sv
// Checker for threshold_run_merger_histogram: watches the cfg, s_ and m_ channels,
// predicts every result word from its own copy of the block state and compares it.
// Depends on trmh_pkg for field widths, word layout and codes.
`default_nettype none

module trmh_checker import trmh_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic                 s_tlast,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 m_tuser,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [COUNT_W-1:0]   cfg_data,
    output int                        mismatches,
    output int                        outstanding
);

    typedef struct packed {
        logic               kind;
        logic [START_W-1:0] start_bin;
        logic [POS_W-1:0]   end_bin;
        logic [SUM_W-1:0]   reads;
        logic [HVAL_W-1:0]  hist_count;
        logic [TOTAL_W-1:0] marked;
    } bin_result_t;

    bin_result_t        due_results[$];
    logic [HVAL_W-1:0]  hist_tbl [0:HIST_DEPTH-1];
    logic [POS_W-1:0]   bin_pos;
    logic               run_active;
    logic [START_W-1:0] run_begin;
    logic [SUM_W-1:0]   run_total;
    logic [TOTAL_W-1:0] marked_cnt;
    logic [COUNT_W-1:0] thresh;

    task automatic close_run();
        bin_result_t r;
        r = '0;
        r.kind      = KIND_RUN;
        r.start_bin = run_begin;
        r.end_bin   = bin_pos;
        r.reads     = run_total;
        r.marked    = marked_cnt;
        due_results.push_back(r);
        run_active = 1'b0;
        run_begin  = '0;
        run_total  = '0;
    endtask

    task automatic read_hist(input logic [IDX_W-1:0] idx);
        bin_result_t r;
        r = '0;
        r.kind   = KIND_HIST;
        r.marked = marked_cnt;
        if (idx <= IDX_W'(HIST_CLIP)) begin
            r.hist_count = hist_tbl[idx];
        end
        due_results.push_back(r);
    endtask

    task automatic take_bin(input logic [COUNT_W-1:0] cnt, input logic first,
                            input logic last);
        logic [HIST_AW-1:0] slot;
        logic [SUM_W:0]     sum_next;
        logic               hot;
        if (first) begin
            bin_pos    = '0;
            run_active = 1'b0;
            run_begin  = '0;
            run_total  = '0;
        end
        slot = (cnt > COUNT_W'(HIST_CLIP)) ? HIST_AW'(HIST_CLIP) : HIST_AW'(cnt);
        if (hist_tbl[slot] != '1) begin
            hist_tbl[slot] = hist_tbl[slot] + 1'b1;
        end
        hot = cnt > thresh;
        if (hot && marked_cnt != '1) begin
            marked_cnt = marked_cnt + 1'b1;
        end
        if (bin_pos >= POS_W'(MAX_BINS)) begin
            bin_pos = POS_W'(MAX_BINS);
            if (run_active) begin
                close_run();
            end
        end else if (hot) begin
            if (!run_active) begin
                run_active = 1'b1;
                run_begin  = bin_pos[START_W-1:0];
                run_total  = SUM_W'(cnt);
            end else begin
                sum_next  = {1'b0, run_total} + (SUM_W+1)'(cnt);
                run_total = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
            end
            bin_pos = bin_pos + 1'b1;
            if (last) begin
                close_run();
            end
        end else begin
            if (run_active) begin
                close_run();
            end
            bin_pos = bin_pos + 1'b1;
        end
    endtask

    task automatic compare_field(input string label, input logic [SUM_W-1:0] want,
                                 input logic [SUM_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, label, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        bin_result_t want;
        bin_result_t got;
        got.kind       = m_tuser;
        got.start_bin  = m_tdata[M_START_LO +: START_W];
        got.end_bin    = m_tdata[M_END_LO +: POS_W];
        got.reads      = m_tdata[M_READS_LO +: SUM_W];
        got.hist_count = m_tdata[M_HVAL_LO +: HVAL_W];
        got.marked     = m_tdata[M_TOTAL_LO +: TOTAL_W];
        if (due_results.size() == 0) begin
            $display("%0t: unexpected result word: expected none, actual kind %0h tdata %0h",
                     $time, m_tuser, m_tdata);
            mismatches++;
        end else begin
            want = due_results.pop_front();
            compare_field("result_kind", SUM_W'(want.kind), SUM_W'(got.kind));
            compare_field("run_start_bin", SUM_W'(want.start_bin), SUM_W'(got.start_bin));
            compare_field("run_end_bin", SUM_W'(want.end_bin), SUM_W'(got.end_bin));
            compare_field("run_reads", want.reads, got.reads);
            compare_field("hist_value", SUM_W'(want.hist_count), SUM_W'(got.hist_count));
            compare_field("marked_bins", SUM_W'(want.marked), SUM_W'(got.marked));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                hist_tbl[k] = '0;
            end
            bin_pos    = '0;
            run_active = 1'b0;
            run_begin  = '0;
            run_total  = '0;
            marked_cnt = '0;
            thresh     = '0;
            mismatches = 0;
            due_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                thresh = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == REQ_HIST) begin
                    read_hist(s_tdata[S_IDX_LO +: IDX_W]);
                end else begin
                    take_bin(s_tdata[S_COUNT_LO +: COUNT_W], s_tdata[S_FIRST_BIT], s_tlast);
                end
            end
            if (m_tvalid && m_tready) begin
                check_result();
            end
        end
        outstanding = due_results.size();
    end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Top of the threshold_run_merger_histogram regression: clock, reset, threshold
// writes and bin/histogram-read stimulus with random idling on both channels.
// Depends on trmh_pkg, the block under test and trmh_checker.
`default_nettype none

module testbench;
    import trmh_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 8;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data;

    int check_errors;
    int outstanding;
    int thr_now       = 0;
    bit gaps_on       = 1'b1;
    bit sink_idle_on  = 1'b1;
    bit sink_hold_req = 1'b0;

    always #1 aclk = ~aclk;

    threshold_run_merger_histogram u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    trmh_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (check_errors),
        .outstanding (outstanding)
    );

    task automatic send_word(input logic req, input logic [COUNT_W-1:0] cnt,
                             input logic first, input logic last,
                             input logic [IDX_W-1:0] idx);
        logic [S_TDATA_W-1:0] word;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        word = '0;
        word[S_COUNT_LO +: COUNT_W] = cnt;
        word[S_FIRST_BIT]           = first;
        word[S_IDX_LO +: IDX_W]     = idx;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= req;
        s_tlast  <= last;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic bin(input logic [COUNT_W-1:0] cnt, input logic first, input logic last);
        send_word(REQ_BIN, cnt, first, last, IDX_W'($urandom));
    endtask

    task automatic hist_read(input logic [IDX_W-1:0] idx);
        send_word(REQ_HIST, COUNT_W'($urandom), 1'($urandom), 1'($urandom), idx);
    endtask

    // hold input off until every expected word is back and the pipe has emptied
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_threshold(input int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= COUNT_W'(value);
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        thr_now = value;
    endtask

    function automatic logic [COUNT_W-1:0] pick_count(input bit hot);
        int lo;
        int hi;
        if ($urandom_range(0, 3) == 0) begin
            return COUNT_W'($urandom);
        end
        if (hot && thr_now < 65535) begin
            lo = thr_now + 1;
            hi = 65535;
            if ($urandom_range(0, 1) == 0 && hi > lo + 3) hi = lo + 3;
        end else begin
            lo = 0;
            hi = thr_now;
            if ($urandom_range(0, 1) == 0 && hi > 3) lo = hi - 3;
        end
        return COUNT_W'($urandom_range(lo, hi));
    endfunction

    task automatic random_phase(input int items, input bit idling);
        int left;
        int len;
        int i;
        bit last;
        logic [IDX_W-1:0] idx;
        left = items;
        gaps_on = idling;
        sink_idle_on = idling;
        while (left > 0) begin
            if (idling && $urandom_range(0, 11) == 0) begin
                gaps_on = 1'($urandom_range(0, 1));
                sink_idle_on = 1'($urandom_range(0, 1));
            end
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 2))
                        0: idx = IDX_W'($urandom);
                        1: idx = IDX_W'(HIST_CLIP);
                        default: idx = (thr_now > HIST_CLIP) ? IDX_W'(HIST_CLIP)
                                      : IDX_W'(thr_now + $urandom_range(0, 3));
                    endcase
                    hist_read(idx);
                    left--;
                end
                1: begin
                    bin(COUNT_W'($urandom), 1'($urandom), 1'($urandom));
                    left--;
                end
                default: begin
                    len = $urandom_range(1, 24);
                    for (i = 0; i < len; i++) begin
                        last = (i == len - 1) && ($urandom_range(0, 7) != 0);
                        bin(pick_count($urandom_range(0, 2) != 0), i == 0, last);
                    end
                    left -= len;
                end
            endcase
        end
    endtask

    initial begin : result_sink
        int n;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold_req) begin
                m_tready <= 1'b0;
                for (n = 1; n < LONG_HOLD; n++) @(posedge aclk);
                sink_hold_req = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("threshold_run_merger_histogram regression: fail");
        $finish;
    end

    initial begin : stimulus
        int p;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        write_threshold(0);
        hist_read(IDX_W'(0));
        hist_read(IDX_W'(HIST_CLIP));
        hist_read(IDX_W'(2047));
        bin(16'd5, 1'b1, 1'b0);
        bin(16'd0, 1'b0, 1'b0);
        bin(16'hFFFF, 1'b0, 1'b0);
        bin(16'hFFFF, 1'b0, 1'b1);
        // numbering continues past a last word without a first word
        bin(16'd3, 1'b0, 1'b0);
        bin(16'd0, 1'b0, 1'b0);
        // drop the open run on a first word
        bin(16'd7, 1'b0, 1'b0);
        bin(16'd9, 1'b1, 1'b0);
        bin(16'd4, 1'b0, 1'b0);
        bin(16'd0, 1'b0, 1'b1);
        bin(16'd1024, 1'b1, 1'b1);
        bin(16'd1025, 1'b1, 1'b0);
        bin(16'd0, 1'b0, 1'b1);
        hist_read(IDX_W'(0));
        hist_read(IDX_W'(HIST_CLIP));
        hist_read(IDX_W'(HIST_CLIP + 1));
        hist_read(IDX_W'(5));

        write_threshold(65535);
        bin(16'hFFFF, 1'b1, 1'b0);
        bin(16'hFFFE, 1'b0, 1'b1);
        hist_read(IDX_W'(HIST_CLIP));

        // close runs on a last word and on an unmarked word
        write_threshold(1000);
        bin(COUNT_W'($urandom_range(0, 1000)), 1'b1, 1'b0);
        bin(COUNT_W'($urandom_range(1001, 65535)), 1'b0, 1'b0);
        bin(16'hFFFF, 1'b0, 1'b0);
        bin(COUNT_W'($urandom_range(1001, 65535)), 1'b0, 1'b0);
        bin(16'd5000, 1'b0, 1'b0);
        bin(16'd5000, 1'b0, 1'b1);
        bin(16'd0, 1'b0, 1'b0);
        bin(16'd1001, 1'b1, 1'b0);
        bin(16'd0, 1'b0, 1'b0);
        hist_read(IDX_W'(HIST_CLIP));
        drain();

        // stall the result side long enough to back up the input
        sink_hold_req = 1'b1;
        for (p = 0; p < 40; p++) begin
            hist_read(IDX_W'($urandom_range(0, HIST_CLIP)));
        end
        drain();

        write_threshold(HIST_CLIP);
        random_phase(110, 1'b1);
        write_threshold($urandom_range(1, 64));
        random_phase(110, 1'b1);
        write_threshold($urandom_range(0, 65535));
        random_phase(110, 1'b1);
        write_threshold(0);
        random_phase(110, 1'b1);
        write_threshold($urandom_range(200, 900));
        random_phase(110, 1'b0);

        drain();
        repeat (20) @(posedge aclk);
        if (check_errors == 0) begin
            $display("threshold_run_merger_histogram regression: pass");
        end else begin
            $display("threshold_run_merger_histogram regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
